// File: src/mtrd_pkg.sv
// Shared types, constants and functions for the ranged-draw generator.
package mtrd_pkg;

    localparam int unsigned STATE_WORDS  = 624;
    localparam int unsigned TWIST_OFFSET = 397;
    localparam int unsigned IDX_W        = 10;
    localparam int unsigned ADDR_W       = 3;

    localparam logic [IDX_W-1:0] IDX_END  = IDX_W'(STATE_WORDS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] IDX_OFS  = IDX_W'(TWIST_OFFSET);

    localparam logic [31:0] SEED_DEFAULT = 32'd5489;
    localparam logic [31:0] MUL_LIN      = 32'd1812433253;
    localparam logic [31:0] MUL_MIX1     = 32'd1664525;
    localparam logic [31:0] MUL_MIX2     = 32'd1566083941;
    localparam logic [31:0] TOP_BIT      = 32'h8000_0000;
    localparam logic [31:0] TWIST_MAG    = 32'h9908_b0df;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;

    // Register index of the seed
    localparam logic [0:0] REG_SEED = 1'b0;

    typedef enum logic [3:0] {
        ST_SEED_INIT,
        ST_LIN_MUL,
        ST_LIN_WR,
        ST_MIX_RD,
        ST_MIX_WR,
        ST_MIX_WRAP,
        ST_SEED_FIN,
        ST_IDLE,
        ST_TW_RD0,
        ST_TW_RD1,
        ST_TW_RD2,
        ST_TW_WR,
        ST_DR_RD,
        ST_DR_TMP,
        ST_DR_MOD,
        ST_DR_OUT
    } state_t;

    // Fixed four-word key of the array mix
    function automatic logic [31:0] mix_key(input logic [1:0] j);
        logic [31:0] k;
        case (j)
            2'd0:    k = 32'h123;
            2'd1:    k = 32'h234;
            2'd2:    k = 32'h345;
            default: k = 32'h456;
        endcase
        return k;
    endfunction

    // Output tempering of one table word
    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// File: src/mtrd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mtrd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/mtrd_mod.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module mtrd_mod import mtrd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] remainder
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] diff;

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
        trial     = {rem_reg, dvd_reg[31]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = diff[32] ? trial[31:0] : diff[31:0];
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    // Done pulses only at the end of a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("remainder done without a run");

endmodule

// File: src/mersenne_twister_ranged_draw_core.sv
// Top level: MT19937 table, seeding, twist and ranged draw with serial modulo.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  input   | s_valid s_ready s_range_low s_range_high       | in
//  result  | m_valid m_ready m_value m_raw_word m_range_error| out
//  config  | APB psel penable pwrite paddr pwdata prdata    | in/out
//
// A draw runs from accept to the next s_ready through accept, read, temper and
// load, the serial remainder unit (32 steps plus done) and output, which waits while
// the output register still holds an unaccepted result. An error draw skips the remainder.
// Every 624th draw first twists the table, reading the operands of each word one
// after another over the single read port of the table RAM.
// After reset and after each seed write the table is reseeded, and s_ready stays
// low until seeding ends.
// A finished result waits in the output register until m_ready.
module mersenne_twister_ranged_draw_core import mtrd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_range_low,
    input  logic signed [31:0]  s_range_high,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_value,
    output logic [31:0]         m_raw_word,
    output logic                m_range_error,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    state_t state_reg, state_next;

    logic [31:0]      seed_reg;
    logic [31:0]      p_reg, p_next;
    logic [31:0]      prod_reg, prod_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [1:0]       j_reg, j_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             phase_c_reg, phase_c_next;
    logic [IDX_W-1:0] ridx_reg, ridx_next;
    logic [IDX_W-1:0] kk_reg, kk_next;
    logic [31:0]      a_reg, a_next;
    logic [31:0]      lo_reg, lo_next;
    logic [31:0]      hi_reg, hi_next;
    logic [31:0]      word_reg, word_next;
    logic             err_reg, err_next;
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      m_value_reg, m_value_next;
    logic [31:0]      m_raw_reg, m_raw_next;
    logic             m_err_reg, m_err_next;

    logic             cfg_wr;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    logic [31:0]      ram_wdata;
    logic [31:0]      ram_rdata;

    logic [31:0]      mul_x;
    logic [31:0]      mul_k;
    logic [63:0]      mul_full;
    logic [31:0]      w_lin;
    logic [31:0]      w_mix;
    logic [31:0]      w_tw;
    logic [IDX_W-1:0] kk_plus1;
    logic [IDX_W:0]   kk_ofs_sum;
    logic [IDX_W-1:0] kk_ofs;
    logic [32:0]      span;
    logic             span_bad;
    logic [31:0]      tempered;
    logic             mod_start;
    logic             mod_done;
    logic [31:0]      mod_rem;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = seed_reg;
    assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_SEED)
                    && (paddr[1:0] == 2'b00);

    // Table memory
    mtrd_ram #(
        .WIDTH (32),
        .DEPTH (STATE_WORDS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Remainder by the span
    mtrd_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (tempered),
        .divisor   (span[31:0]),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Shared seeding multiplier, registered every cycle
    assign mul_x     = p_reg ^ (p_reg >> 30);
    assign mul_k     = (state_reg == ST_LIN_MUL) ? MUL_LIN
                     : (phase_c_reg ? MUL_MIX2 : MUL_MIX1);
    assign mul_full  = mul_x * mul_k;
    assign prod_next = mul_full[31:0];

    // Seeding word values
    assign w_lin = prod_reg + {22'd0, i_reg};
    assign w_mix = phase_c_reg ? ((ram_rdata ^ prod_reg) - {22'd0, i_reg})
                               : ((ram_rdata ^ prod_reg) + mix_key(j_reg) + {30'd0, j_reg});

    // Twist indexes and new word
    assign kk_plus1   = (kk_reg == IDX_LAST) ? '0 : kk_reg + 1'b1;
    assign kk_ofs_sum = {1'b0, kk_reg} + {1'b0, IDX_OFS};
    assign kk_ofs     = (kk_ofs_sum >= {1'b0, IDX_END})
                      ? IDX_W'(kk_ofs_sum - {1'b0, IDX_END}) : kk_ofs_sum[IDX_W-1:0];
    assign w_tw       = ram_rdata;

    // Draw arithmetic
    assign span     = {hi_reg[31], hi_reg} - {lo_reg[31], lo_reg};
    assign span_bad = span[32] || (span == 33'd0);
    assign tempered = temper(ram_rdata);

    // Next state and datapath control
    always_comb begin
        state_next   = state_reg;
        p_next       = p_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        cnt_next     = cnt_reg;
        phase_c_next = phase_c_reg;
        ridx_next    = ridx_reg;
        kk_next      = kk_reg;
        a_next       = a_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        word_next    = word_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        m_raw_next   = m_raw_reg;
        m_err_next   = m_err_reg;
        ram_we       = 1'b0;
        ram_waddr    = i_reg;
        ram_wdata    = w_mix;
        ram_raddr    = i_reg;
        s_ready      = 1'b0;
        mod_start    = 1'b0;

        case (state_reg)
            ST_SEED_INIT: begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = seed_reg;
                p_next     = seed_reg;
                i_next     = IDX_W'(1);
                state_next = ST_LIN_MUL;
            end
            ST_LIN_MUL: begin
                state_next = ST_LIN_WR;
            end
            ST_LIN_WR: begin
                ram_we    = 1'b1;
                ram_wdata = w_lin;
                p_next    = w_lin;
                if (i_reg == IDX_LAST) begin
                    // Mix starts from word 0, which still holds the seed
                    p_next       = seed_reg;
                    i_next       = IDX_W'(1);
                    j_next       = '0;
                    cnt_next     = IDX_END;
                    phase_c_next = 1'b0;
                    state_next   = ST_MIX_RD;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_LIN_MUL;
                end
            end
            ST_MIX_RD: begin
                state_next = ST_MIX_WR;
            end
            ST_MIX_WR: begin
                ram_we   = 1'b1;
                p_next   = w_mix;
                j_next   = j_reg + 2'd1;
                cnt_next = cnt_reg - 1'b1;
                i_next   = (i_reg == IDX_LAST) ? IDX_W'(1) : i_reg + 1'b1;
                if (cnt_reg == IDX_W'(1)) begin
                    phase_c_next = 1'b1;
                    cnt_next     = IDX_LAST;
                end
                if (phase_c_reg && cnt_reg == IDX_W'(1)) begin
                    state_next = ST_SEED_FIN;
                end else if (i_reg == IDX_LAST) begin
                    state_next = ST_MIX_WRAP;
                end else begin
                    state_next = ST_MIX_RD;
                end
            end
            ST_MIX_WRAP: begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = p_reg;
                state_next = ST_MIX_RD;
            end
            ST_SEED_FIN: begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = TOP_BIT;
                ridx_next  = IDX_END;
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    lo_next = s_range_low;
                    hi_next = s_range_high;
                    if (ridx_reg == IDX_END) begin
                        kk_next    = '0;
                        state_next = ST_TW_RD0;
                    end else begin
                        state_next = ST_DR_RD;
                    end
                end
            end
            ST_TW_RD0: begin
                ram_raddr  = kk_reg;
                state_next = ST_TW_RD1;
            end
            ST_TW_RD1: begin
                ram_raddr  = kk_plus1;
                a_next     = ram_rdata;
                state_next = ST_TW_RD2;
            end
            ST_TW_RD2: begin
                ram_raddr  = kk_ofs;
                a_next     = {a_reg[31], ram_rdata[30:0]};
                state_next = ST_TW_WR;
            end
            ST_TW_WR: begin
                ram_we    = 1'b1;
                ram_waddr = kk_reg;
                ram_wdata = w_tw ^ (a_reg >> 1) ^ (a_reg[0] ? TWIST_MAG : 32'd0);
                if (kk_reg == IDX_LAST) begin
                    ridx_next  = '0;
                    state_next = ST_DR_RD;
                end else begin
                    kk_next    = kk_plus1;
                    state_next = ST_TW_RD0;
                end
            end
            ST_DR_RD: begin
                ram_raddr  = ridx_reg;
                state_next = ST_DR_TMP;
            end
            ST_DR_TMP: begin
                word_next = tempered;
                err_next  = span_bad;
                ridx_next = ridx_reg + 1'b1;
                if (span_bad) begin
                    state_next = ST_DR_OUT;
                end else begin
                    mod_start  = 1'b1;
                    state_next = ST_DR_MOD;
                end
            end
            ST_DR_MOD: begin
                if (mod_done) begin
                    state_next = ST_DR_OUT;
                end
            end
            ST_DR_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = err_reg ? 32'd0 : lo_reg + mod_rem;
                    m_raw_next   = word_reg;
                    m_err_next   = err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_SEED_INIT;
            end
        endcase

        // A seed write restarts seeding
        if (cfg_wr) begin
            s_ready    = 1'b0;
            lo_next    = lo_reg;
            hi_next    = hi_reg;
            state_next = ST_SEED_INIT;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SEED_INIT;
            seed_reg    <= SEED_DEFAULT;
            ridx_reg    <= IDX_END;
            m_valid_reg <= 1'b0;
            phase_c_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            cnt_reg     <= '0;
            kk_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            ridx_reg    <= ridx_next;
            m_valid_reg <= m_valid_next;
            phase_c_reg <= phase_c_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            cnt_reg     <= cnt_next;
            kk_reg      <= kk_next;
            if (cfg_wr) begin
                seed_reg <= pwdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        p_reg       <= p_next;
        prod_reg    <= prod_next;
        a_reg       <= a_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        word_reg    <= word_next;
        err_reg     <= err_next;
        m_value_reg <= m_value_next;
        m_raw_reg   <= m_raw_next;
        m_err_reg   <= m_err_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_value       = m_value_reg;
    assign m_raw_word    = m_raw_reg;
    assign m_range_error = m_err_reg;

    // Read pointer never passes the end of the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        ridx_reg <= IDX_END)
        else $error("read index past table end");

    // An error result carries zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_err_reg) |-> (m_value_reg == 32'd0))
        else $error("error result with nonzero value");

    // Remainder completes only while a draw waits on it, unless a seed write has just restarted seeding
    assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> (state_reg == ST_DR_MOD) || $past(cfg_wr))
        else $error("remainder done outside a draw");

    // A new transaction is taken only with a table that has words left or twists first
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DR_RD) |-> (ridx_reg != IDX_END))
        else $error("draw read past table end");

endmodule

// File: tb/tb_mersenne_twister_ranged_draw_core.sv
// Testbench for the ranged-draw generator: self-checking against an in-bench MT19937 predictor.
module tb_mersenne_twister_ranged_draw_core import mtrd_pkg::*;;

    localparam int HOLD_CYCLES   = 500;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 60;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic signed [31:0] value;
        logic [31:0]        raw_word;
        logic               range_error;
    } draw_t;

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic               known;
        logic signed [31:0] value;
        logic               range_error;
    } draw_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic signed [31:0]  s_range_low = '0;
    logic signed [31:0]  s_range_high = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic signed [31:0]  m_value;
    logic [31:0]         m_raw_word;
    logic                m_range_error;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Predictor state: table, read pointer and queue of expected results
    logic [31:0] gen_table [STATE_WORDS];
    int unsigned gen_pos;
    draw_t       pending_draws[$];

    int fail_count = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    mersenne_twister_ranged_draw_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_range_low(s_range_low), .s_range_high(s_range_high),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_value(m_value), .m_raw_word(m_raw_word), .m_range_error(m_range_error),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Fill the table from a seed: linear routine, then keyed mix
    function automatic void seed_generator(input logic [31:0] seed);
        logic [31:0] p;
        logic [31:0] key;
        int unsigned i;
        int unsigned j;
        gen_table[0] = seed;
        for (int n = 1; n < STATE_WORDS; n++) begin
            p = gen_table[n-1];
            gen_table[n] = MUL_LIN * (p ^ (p >> 30)) + 32'(n);
        end
        i = 1;
        j = 0;
        for (int k = STATE_WORDS; k > 0; k--) begin
            p = gen_table[i-1];
            case (j)
                0:       key = 32'h123;
                1:       key = 32'h234;
                2:       key = 32'h345;
                default: key = 32'h456;
            endcase
            gen_table[i] = (gen_table[i] ^ (MUL_MIX1 * (p ^ (p >> 30)))) + key + 32'(j);
            i++;
            j++;
            if (i >= STATE_WORDS) begin
                gen_table[0] = gen_table[STATE_WORDS-1];
                i = 1;
            end
            if (j >= 4) j = 0;
        end
        for (int k = STATE_WORDS - 1; k > 0; k--) begin
            p = gen_table[i-1];
            gen_table[i] = (gen_table[i] ^ (MUL_MIX2 * (p ^ (p >> 30)))) - 32'(i);
            i++;
            if (i >= STATE_WORDS) begin
                gen_table[0] = gen_table[STATE_WORDS-1];
                i = 1;
            end
        end
        gen_table[0] = TOP_BIT;
        gen_pos = STATE_WORDS;
    endfunction

    // Advance the generator by one tempered word, regenerating when exhausted
    function automatic logic [31:0] draw_word();
        logic [31:0] y;
        if (gen_pos >= STATE_WORDS) begin
            for (int kk = 0; kk < STATE_WORDS; kk++) begin
                y = (gen_table[kk] & TOP_BIT)
                    | (gen_table[(kk + 1) % STATE_WORDS] & ~TOP_BIT);
                gen_table[kk] = gen_table[(kk + TWIST_OFFSET) % STATE_WORDS]
                                ^ (y >> 1) ^ (y[0] ? TWIST_MAG : 32'h0);
            end
            gen_pos = 0;
        end
        y = gen_table[gen_pos];
        gen_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Expected result of one ranged draw
    function automatic draw_t predict_draw(input logic signed [31:0] lo,
                                           input logic signed [31:0] hi);
        draw_t d;
        longint span;
        longint v;
        d.raw_word = draw_word();
        span = longint'(hi) - longint'(lo);
        if (span <= 0) begin
            d.value = '0;
            d.range_error = 1'b1;
        end else begin
            v = longint'(lo) + longint'({32'h0, d.raw_word} % span);
            d.value = v[31:0];
            d.range_error = 1'b0;
        end
        return d;
    endfunction

    // Offer one transaction and queue its expectation once accepted
    task automatic send_draw(input draw_row_t row);
        draw_t d;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_range_low <= row.lo;
        s_range_high <= row.hi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        d = predict_draw(row.lo, row.hi);
        if (row.known) begin
            d.value = row.value;
            d.range_error = row.range_error;
        end
        pending_draws.push_back(d);
    endtask

    // Random draw: narrow spans most often, plus wide, inverted and power-of-two spans
    task automatic send_random();
        draw_row_t row;
        longint span;
        int pick;
        pick = $urandom_range(99);
        row.known = 1'b0;
        row.value = '0;
        row.range_error = 1'b0;
        row.lo = $urandom;
        row.hi = $urandom;
        if (pick < 8) begin
            if (row.hi > row.lo) begin
                row.hi = row.lo;
                row.lo = $urandom;
                if (row.lo < row.hi) row.lo = row.hi;
            end
        end else if (pick < 55 || pick >= 80) begin
            span = (pick < 55) ? longint'($urandom_range(1, 1000))
                               : longint'(1) << $urandom_range(0, 31);
            if (longint'(row.lo) + span > longint'(S_MAX)) row.lo = 32'(longint'(S_MAX) - span);
            row.hi = 32'(longint'(row.lo) + span);
        end
        send_draw(row);
    endtask

    // Wait out outstanding results, then write the seed over APB
    task automatic write_seed(input logic [31:0] seed);
        s_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * REG_SEED);
        pwdata <= seed;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        seed_generator(seed);
    endtask

    // Result side: check each transaction, then pick the next ready level
    always @(posedge aclk) begin
        draw_t exp_d;
        if (m_valid && m_ready) begin
            if (pending_draws.size() == 0) begin
                $error("unexpected result: value %0d raw_word %h", m_value, m_raw_word);
                fail_count++;
            end else begin
                exp_d = pending_draws.pop_front();
                if (m_value !== exp_d.value) begin
                    $error("value: expected %0d, got %0d", exp_d.value, m_value);
                    fail_count++;
                end
                if (m_raw_word !== exp_d.raw_word) begin
                    $error("raw_word: expected %h, got %h", exp_d.raw_word, m_raw_word);
                    fail_count++;
                end
                if (m_range_error !== exp_d.range_error) begin
                    $error("range_error: expected %0b, got %0b",
                           exp_d.range_error, m_range_error);
                    fail_count++;
                end
            end
        end
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Watchdog: count cycles with no transaction on any port
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL mersenne_twister_ranged_draw_core");
            $finish;
        end
    end

    initial begin
        draw_row_t directed [16];
        directed = '{
            '{S_MIN, S_MAX, 1'b0, 32'sd0, 1'b0},
            '{32'sd0, 32'sd1, 1'b1, 32'sd0, 1'b0},
            '{-32'sd1, 32'sd0, 1'b1, -32'sd1, 1'b0},
            '{S_MAX - 1, S_MAX, 1'b1, S_MAX - 1, 1'b0},
            '{S_MIN, S_MIN + 1, 1'b1, S_MIN, 1'b0},
            '{32'sd0, 32'sd0, 1'b1, 32'sd0, 1'b1},
            '{S_MAX, S_MIN, 1'b1, 32'sd0, 1'b1},
            '{S_MIN, S_MIN, 1'b1, 32'sd0, 1'b1},
            '{S_MAX, S_MAX, 1'b1, 32'sd0, 1'b1},
            '{-32'sd1, S_MIN, 1'b1, 32'sd0, 1'b1},
            '{32'sd1, -32'sd1, 1'b1, 32'sd0, 1'b1},
            '{32'sd0, S_MAX, 1'b0, 32'sd0, 1'b0},
            '{S_MIN, 32'sd0, 1'b0, 32'sd0, 1'b0},
            '{-32'sd100, 32'sd100, 1'b0, 32'sd0, 1'b0},
            '{32'sd0, 32'sd2, 1'b0, 32'sd0, 1'b0},
            '{32'sd0, 32'sh10000, 1'b0, 32'sd0, 1'b0}
        };
        seed_generator(SEED_DEFAULT);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Default seed, sender light and receiver heavy idling; runs past two twists
        snd_idle_pct = 23;
        rcv_idle_pct = 77;
        foreach (directed[r]) send_draw(directed[r]);
        repeat (640) send_random();

        // All-ones seed, the idling swapped; pause until drained midway
        write_seed(32'hffff_ffff);
        snd_idle_pct = 77;
        rcv_idle_pct = 23;
        repeat (150) send_random();
        s_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge aclk);
        repeat (150) send_random();

        // Zero seed, no idling
        write_seed(32'h0);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        repeat (300) send_random();

        // Random seed; receiver stalls long while draws keep coming
        write_seed($urandom);
        hold_seq++;
        repeat (294) send_random();

        s_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS mersenne_twister_ranged_draw_core");
        else
            $display("FAIL mersenne_twister_ranged_draw_core");
        $finish;
    end

endmodule
